FILE: sv/rc_pkg.sv
// Shared constants, microcode types and control store of the radix converter.
package rc_pkg;

    localparam int VALUE_W  = 40;
    localparam int DIGIT_W  = 4;
    localparam int RADIX_W  = 5;
    localparam int DEC_BASE = 10;
    localparam int MIN_RADIX = 2;
    localparam int DIV_STEP = 4;     // quotient bits per divider step
    localparam int PC_W     = 4;

    typedef enum logic [3:0] {
        OP_NOP,
        OP_ACCEPT,
        OP_DIV_RADIX,
        OP_DIV_DEC,
        OP_DIV_STEP,
        OP_PUSH_REM,
        OP_PUSH_ZERO,
        OP_MAC,
        OP_EMIT_DIGIT,
        OP_EMIT_VALUE
    } op_t;

    typedef enum logic [3:0] {
        C_NEVER,
        C_ALWAYS,
        C_NO_BEAT,
        C_MODE1,
        C_WORK_ZERO,
        C_DIV_MORE,
        C_MORE_DIGITS,
        C_DIGIT_PEND,
        C_OUT_BUSY
    } cond_t;

    typedef struct packed {
        op_t              op;
        cond_t            cond;
        logic [PC_W-1:0]  target;
    } ctrl_t;

    // Program addresses
    localparam logic [PC_W-1:0] PC_IDLE       = 4'd0;
    localparam logic [PC_W-1:0] PC_DISPATCH   = 4'd1;
    localparam logic [PC_W-1:0] PC_ZERO_CHK   = 4'd2;
    localparam logic [PC_W-1:0] PC_RDX_START  = 4'd3;
    localparam logic [PC_W-1:0] PC_RDX_LOOP   = 4'd4;
    localparam logic [PC_W-1:0] PC_RDX_PUSH   = 4'd5;
    localparam logic [PC_W-1:0] PC_EMIT_DIG   = 4'd6;
    localparam logic [PC_W-1:0] PC_DIG_DONE   = 4'd7;
    localparam logic [PC_W-1:0] PC_ZERO_PUSH  = 4'd8;
    localparam logic [PC_W-1:0] PC_DEC_START  = 4'd9;
    localparam logic [PC_W-1:0] PC_DEC_LOOP   = 4'd10;
    localparam logic [PC_W-1:0] PC_DEC_MAC    = 4'd11;
    localparam logic [PC_W-1:0] PC_EMIT_VAL   = 4'd12;
    localparam logic [PC_W-1:0] PC_VAL_DONE   = 4'd13;

    // Control store: branch to target when cond holds, else fall through.
    function automatic ctrl_t ucode(input logic [PC_W-1:0] pc);
        ctrl_t w;
        case (pc)
            PC_IDLE:      w = '{OP_ACCEPT,     C_NO_BEAT,     PC_IDLE};
            PC_DISPATCH:  w = '{OP_NOP,        C_MODE1,       PC_DEC_START};
            PC_ZERO_CHK:  w = '{OP_NOP,        C_WORK_ZERO,   PC_ZERO_PUSH};
            PC_RDX_START: w = '{OP_DIV_RADIX,  C_NEVER,       PC_IDLE};
            PC_RDX_LOOP:  w = '{OP_DIV_STEP,   C_DIV_MORE,    PC_RDX_LOOP};
            PC_RDX_PUSH:  w = '{OP_PUSH_REM,   C_MORE_DIGITS, PC_RDX_START};
            PC_EMIT_DIG:  w = '{OP_EMIT_DIGIT, C_DIGIT_PEND,  PC_EMIT_DIG};
            PC_DIG_DONE:  w = '{OP_NOP,        C_ALWAYS,      PC_IDLE};
            PC_ZERO_PUSH: w = '{OP_PUSH_ZERO,  C_ALWAYS,      PC_EMIT_DIG};
            PC_DEC_START: w = '{OP_DIV_DEC,    C_WORK_ZERO,   PC_EMIT_VAL};
            PC_DEC_LOOP:  w = '{OP_DIV_STEP,   C_DIV_MORE,    PC_DEC_LOOP};
            PC_DEC_MAC:   w = '{OP_MAC,        C_ALWAYS,      PC_DEC_START};
            PC_EMIT_VAL:  w = '{OP_EMIT_VALUE, C_OUT_BUSY,    PC_EMIT_VAL};
            PC_VAL_DONE:  w = '{OP_NOP,        C_ALWAYS,      PC_IDLE};
            default:      w = '{OP_NOP,        C_ALWAYS,      PC_IDLE};
        endcase
        return w;
    endfunction

endpackage

FILE: sv/rc_cfg_if.sv
// Configuration write channel carrying the radix register.
interface rc_cfg_if;
    logic       valid;
    logic       ready;
    logic [4:0] radix;

    modport source (output valid, output radix, input ready);
    modport sink   (input valid, input radix, output ready);
endinterface

FILE: sv/rc_in_if.sv
// Input channel: conversion mode and number.
interface rc_in_if #(
    parameter int NUMBER_W = 31
);
    logic                valid;
    logic                ready;
    logic                mode;
    logic [NUMBER_W-1:0] number;

    modport source (output valid, output mode, output number, input ready);
    modport sink   (input valid, input mode, input number, output ready);
endinterface

FILE: sv/rc_out_if.sv
// Result channel: digit, value and last marker.
interface rc_out_if;
    logic        valid;
    logic        ready;
    logic [3:0]  digit;
    logic [39:0] value;
    logic        last;

    modport source (output valid, output digit, output value, output last, input ready);
    modport sink   (input valid, input digit, input value, input last, output ready);
endinterface

FILE: sv/radix_converter_top.sv
// Radix converter: microcoded sequencer over a shared 4-bit-per-step divider.
//
// Channels: cfg writes the radix (always ready, clamped to 2..MAX_RADIX on use).
// req carries mode and number; rsp returns digit, value and last.
// Mode 0 emits the base-n digits of number, most significant first, one beat
// per digit with last on the final one; zero gives a single digit 0.
// Mode 1 reads the decimal digits of number as base-n digits and returns
// their value (mod 2^40) in a single beat with last set.
// Every digit costs one pass of the divider over CHUNKS = ceil(VALUE_BITS/4)
// dividend chunks, plus a setup step and a store step. The division loop
// sets the throughput; one item is converted at a time.
// A result stays in the output register while rsp.ready is low; the
// sequencer waits at its emit step and takes the next item once the last
// beat is loaded. Reset returns the sequencer to idle, radix to 2 and
// drops any pending result.
module radix_converter_top #(
    parameter int VALUE_BITS = 31,
    parameter int MAX_DIGITS = 31,
    parameter int MAX_RADIX  = 16
) (
    input  logic      clk,
    input  logic      rst_n,
    rc_cfg_if.sink    cfg,
    rc_in_if.sink     req,
    rc_out_if.source  rsp
);
    import rc_pkg::*;

    localparam int CHUNKS  = (VALUE_BITS + DIV_STEP - 1) / DIV_STEP;
    localparam int PW      = CHUNKS * DIV_STEP;
    localparam int CHUNK_W = $clog2(CHUNKS);
    localparam int DIV_W   = $clog2(MAX_RADIX + 1);
    localparam int CMP_W   = (DIV_W > RADIX_W) ? DIV_W : RADIX_W;
    localparam int CNT_W   = $clog2(MAX_DIGITS + 1);
    localparam int IDX_W   = $clog2(MAX_DIGITS);

    logic [PC_W-1:0]    pc_reg, pc_next;
    ctrl_t              ctrl;
    logic               take;
    logic [RADIX_W-1:0] radix_reg;
    logic               mode_reg;
    logic [PW-1:0]      work_reg;
    logic [DIV_W-1:0]   rem_reg;
    logic [DIV_W-1:0]   div_reg;
    logic [CHUNK_W-1:0] chunk_reg;
    logic [CNT_W-1:0]   cnt_reg;
    logic [CNT_W-1:0]   cnt_dec;
    logic [VALUE_W-1:0] acc_reg;
    logic [VALUE_W-1:0] weight_reg;
    logic [DIGIT_W-1:0] store [MAX_DIGITS];
    logic               out_valid_reg;
    logic [DIGIT_W-1:0] out_digit_reg;
    logic [VALUE_W-1:0] out_value_reg;
    logic               out_last_reg;

    logic [CMP_W-1:0]   radix_ext;
    logic [DIV_W-1:0]   base_eff;
    logic [PW-1:0]      q_work;
    logic [DIV_W-1:0]   q_rem;
    logic [VALUE_W+DIGIT_W-1:0] dprod;
    logic [VALUE_W+DIV_W-1:0]   wprod;
    logic               beat_in;
    logic               out_free;
    logic               emit_dig;
    logic               emit_val;

    assign ctrl     = ucode(pc_reg);
    assign beat_in  = req.valid && req.ready;
    assign out_free = !out_valid_reg || rsp.ready;
    assign emit_dig = (ctrl.op == OP_EMIT_DIGIT) && out_free;
    assign emit_val = (ctrl.op == OP_EMIT_VALUE) && out_free;
    assign cnt_dec  = cnt_reg - CNT_W'(1);

    assign cfg.ready = 1'b1;
    assign req.ready = (ctrl.op == OP_ACCEPT);
    assign rsp.valid = out_valid_reg;
    assign rsp.digit = out_digit_reg;
    assign rsp.value = out_value_reg;
    assign rsp.last  = out_last_reg;

    // Clamp the radix into 2..MAX_RADIX
    assign radix_ext = CMP_W'(radix_reg);
    always_comb
    begin
        if (radix_ext < CMP_W'(MIN_RADIX))
            base_eff = DIV_W'(MIN_RADIX);
        else if (radix_ext > CMP_W'(MAX_RADIX))
            base_eff = DIV_W'(MAX_RADIX);
        else
            base_eff = DIV_W'(radix_ext);
    end

    // One divider step: shift DIV_STEP dividend bits through the remainder,
    // quotient bits enter work from the bottom.
    always_comb
    begin
        logic [DIV_W:0] trial;
        q_work = work_reg;
        q_rem  = rem_reg;
        trial  = '0;
        for (int i = 0; i < DIV_STEP; i++)
        begin
            trial  = {q_rem, q_work[PW-1]};
            q_work = {q_work[PW-2:0], 1'b0};
            if (trial >= {1'b0, div_reg})
            begin
                trial     = trial - {1'b0, div_reg};
                q_work[0] = 1'b1;
            end
            q_rem = trial[DIV_W-1:0];
        end
    end

    // Place weight advances by the base, not by the decimal divisor
    assign dprod = rem_reg[DIGIT_W-1:0] * weight_reg;
    assign wprod = weight_reg * base_eff;

    always_comb
    begin
        case (ctrl.cond)
            C_NEVER:       take = 1'b0;
            C_ALWAYS:      take = 1'b1;
            C_NO_BEAT:     take = !req.valid;
            C_MODE1:       take = mode_reg;
            C_WORK_ZERO:   take = (work_reg == '0);
            C_DIV_MORE:    take = (chunk_reg != '0);
            C_MORE_DIGITS: take = (work_reg != '0) && (cnt_reg != CNT_W'(MAX_DIGITS - 1));
            C_DIGIT_PEND:  take = !out_free || (cnt_reg != CNT_W'(1));
            C_OUT_BUSY:    take = !out_free;
            default:       take = 1'b0;
        endcase
        pc_next = take ? ctrl.target : pc_reg + PC_W'(1);
    end

    // Sequencer and control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pc_reg        <= PC_IDLE;
            radix_reg     <= RADIX_W'(MIN_RADIX);
            cnt_reg       <= '0;
            chunk_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            pc_reg <= pc_next;
            if (cfg.valid)
                radix_reg <= cfg.radix;
            if (emit_dig || emit_val)
                out_valid_reg <= 1'b1;
            else if (rsp.ready)
                out_valid_reg <= 1'b0;
            case (ctrl.op)
                OP_ACCEPT:     if (beat_in) cnt_reg <= '0;
                OP_DIV_RADIX,
                OP_DIV_DEC:    chunk_reg <= CHUNK_W'(CHUNKS - 1);
                OP_DIV_STEP:   chunk_reg <= chunk_reg - CHUNK_W'(1);
                OP_PUSH_REM,
                OP_PUSH_ZERO:  cnt_reg <= cnt_reg + CNT_W'(1);
                OP_EMIT_DIGIT: if (out_free) cnt_reg <= cnt_dec;
                default:       ;
            endcase
        end
    end

    // Datapath, digit memory and result payload
    always_ff @(posedge clk)
    begin
        case (ctrl.op)
            OP_ACCEPT:
            begin
                if (beat_in)
                begin
                    mode_reg   <= req.mode;
                    work_reg   <= PW'(VALUE_BITS'(req.number));
                    acc_reg    <= '0;
                    weight_reg <= VALUE_W'(1);
                end
            end
            OP_DIV_RADIX:
            begin
                rem_reg <= '0;
                div_reg <= base_eff;
            end
            OP_DIV_DEC:
            begin
                rem_reg <= '0;
                div_reg <= DIV_W'(DEC_BASE);
            end
            OP_DIV_STEP:
            begin
                work_reg <= q_work;
                rem_reg  <= q_rem;
            end
            OP_PUSH_REM:   store[cnt_reg[IDX_W-1:0]] <= rem_reg[DIGIT_W-1:0];
            OP_PUSH_ZERO:  store[cnt_reg[IDX_W-1:0]] <= '0;
            OP_MAC:
            begin
                acc_reg    <= acc_reg + dprod[VALUE_W-1:0];
                weight_reg <= wprod[VALUE_W-1:0];
            end
            OP_EMIT_DIGIT:
            begin
                if (out_free)
                begin
                    out_digit_reg <= store[cnt_dec[IDX_W-1:0]];
                    out_value_reg <= '0;
                    out_last_reg  <= (cnt_reg == CNT_W'(1));
                end
            end
            OP_EMIT_VALUE:
            begin
                if (out_free)
                begin
                    out_digit_reg <= '0;
                    out_value_reg <= acc_reg;
                    out_last_reg  <= 1'b1;
                end
            end
            default: ;
        endcase
    end

`ifndef NO_ASSERTIONS
    a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= CNT_W'(MAX_DIGITS))
        else $error("digit count beyond store depth");

    a_rem_below_div: assert property (@(posedge clk) disable iff (!rst_n)
        (pc_reg == PC_RDX_LOOP || pc_reg == PC_DEC_LOOP) |-> rem_reg < div_reg)
        else $error("divider remainder not below divisor");

    a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
        beat_in |=> !req.ready)
        else $error("second item taken before the first finished");

    a_value_last: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp.valid && rsp.value != '0) |-> rsp.last)
        else $error("nonzero value on a digit beat that is not last");
`endif

endmodule
